// ===== hw/rtl/led_color_state_table_macros.svh =====
// Assertion macros used by the LED colour state table module.
`ifndef LED_COLOR_STATE_TABLE_MACROS_SVH
`define LED_COLOR_STATE_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LCST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcst same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LCST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcst next-cycle check failed");

`endif

// ===== hw/rtl/lcst_pkg.sv =====
// Types, codes and the temperature colour curve for the LED colour state table.
package lcst_pkg;

	localparam logic [3:0] REQ_ON     = 4'd0;
	localparam logic [3:0] REQ_OFF    = 4'd1;
	localparam logic [3:0] REQ_TOGGLE = 4'd2;
	localparam logic [3:0] REQ_RGB    = 4'd3;
	localparam logic [3:0] REQ_BRIGHT = 4'd4;
	localparam logic [3:0] REQ_HUE    = 4'd5;
	localparam logic [3:0] REQ_SAT    = 4'd6;
	localparam logic [3:0] REQ_KELVIN = 4'd7;

	localparam int MUL_A_W = 20;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// ceil(2^24/15) and ceil(2^24/100), both exact over the operand ranges used.
	localparam logic [MUL_B_W-1:0] RECIP15  = 21'd1118482;
	localparam logic [MUL_B_W-1:0] RECIP100 = 21'd167773;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_op_t;

	typedef struct packed {
		logic        lit;
		logic        tmode;
		logic [8:0]  hue;
		logic [7:0]  sat;
		logic [7:0]  bri;
		logic [15:0] kel;
		logic [7:0]  blu;
		logic [7:0]  grn;
		logic [7:0]  red;
	} led_entry_t;

	localparam logic [63:0] SCALE_E10 = 64'd10000000000;
	localparam logic [63:0] ONE_Q28   = 64'd268435456;
	localparam logic [63:0] LN2_Q28   = 64'd186065279;

	// Restoring long division; only evaluated while the ROM contents are worked out.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] to_q20(input logic [63:0] c);
		return udiv64(c << 20, SCALE_E10);
	endfunction

	function automatic logic [63:0] ln_q20(input logic [31:0] x);
		logic [63:0] k, mq, z, z2, term, sum;
		k = 0;
		for (int j = 0; j < 31; j++) begin
			if ((x >> (k + 1)) != 0) k = k + 1;
		end
		mq = ({32'd0, x} << 28) >> k;
		z = udiv64((mq - ONE_Q28) << 28, mq + ONE_Q28);
		z2 = (z * z) >> 28;
		term = z;
		sum = z;
		for (int n = 1; n <= 15; n++) begin
			term = (term * z2) >> 28;
			sum = sum + udiv64(term, 64'(2 * n + 1));
		end
		return (k * LN2_Q28 + 2 * sum) >> 8;
	endfunction

	function automatic logic [63:0] exp_q20(input logic [63:0] u);
		logic [63:0] sum, term;
		sum = 64'd1 << 20;
		term = 64'd1 << 20;
		for (int n = 1; n <= 24; n++) begin
			term = udiv64((term * u) >> 20, 64'(n));
			sum = sum + term;
		end
		return sum;
	endfunction

	function automatic logic [7:0] clamp8(input logic [63:0] v);
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [7:0] pow_curve(input logic [63:0] coef, input logic [63:0] expo,
		input logic [31:0] y);
		logic [63:0] u, e;
		u = udiv64(ln_q20(y) * expo, SCALE_E10);
		e = exp_q20(u);
		return clamp8(udiv64(to_q20(coef) << 20, e) >> 20);
	endfunction

	function automatic logic [7:0] log_curve(input logic [63:0] coef, input logic [63:0] off_c,
		input logic [31:0] y);
		logic [63:0] a, off;
		a = udiv64(ln_q20(y) * coef, SCALE_E10);
		off = to_q20(off_c);
		if (a <= off) return 8'd0;
		return clamp8((a - off) >> 20);
	endfunction

	// Temperature colour for kelvin/100 = t, packed blue, green, red from the top down.
	function automatic logic [23:0] kelvin_rgb(input logic [31:0] t);
		logic [7:0] r, g, b;
		if (t <= 66) r = 8'd255;
		else r = pow_curve(64'd3296987274460, 64'd1332047592, t - 60);
		if (t == 0) g = 8'd0;
		else if (t <= 66) g = log_curve(64'd994708025861, 64'd1611195681661, t);
		else g = pow_curve(64'd2881221695283, 64'd755148492, t - 60);
		if (t >= 66) b = 8'd255;
		else if (t <= 19) b = 8'd0;
		else b = log_curve(64'd1385177312231, 64'd3050447927307, t - 10);
		return {b, g, r};
	endfunction

endpackage

// ===== hw/rtl/lcst_ram.sv =====
// Generic single-port RAM with registered read data.
module lcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== hw/rtl/lcst_kelvin_rom.sv =====
// Temperature colour ROM with registered read, contents worked out at elaboration.
module lcst_kelvin_rom #(
	parameter int DEPTH = 656
) (
	input  logic                                       clk,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	output logic [23:0]                                rgb
);
	logic [23:0] rom_w [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		localparam logic [23:0] ENTRY = lcst_pkg::kelvin_rgb(32'(i));
		assign rom_w[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		rgb <= rom_w[addr];
	end
endmodule

// ===== hw/rtl/lcst_mul.sv =====
// Shared multiplier with a registered product, reused across the steps of the sequencer.
module lcst_mul (
	input  logic                           clk,
	input  lcst_pkg::mul_op_t              op,
	output logic [lcst_pkg::MUL_P_W-1:0]   prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= lcst_pkg::MUL_P_W'(op.a) * lcst_pkg::MUL_P_W'(op.b);
	end
endmodule

// ===== hw/rtl/led_color_state_table.sv =====
// An accepted word passes through ST_RD, ST_CALC, ST_WR and ST_OUT before its result can be
// taken; ST_CALC runs its HSV or temperature steps and is skipped when nothing is recomputed
// (LED off, read, raw write), and a rejected index goes from ST_IDLE straight to ST_OUT.
// A new word is taken only once the previous result has left ST_OUT; the shared multiplier
// steps through up to seven products. After reset a clearing pass writes MAX_LEDS zero
// entries, one a cycle, before s_tready rises. Configuration writes are taken throughout.
module led_color_state_table #(
	parameter int MAX_LEDS         = 1024,
	parameter int KELVIN_ROM_DEPTH = 656
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// led_index, red_in, green_in, blue_in, brightness_in, saturation_in, hue_in, kelvin_in
	input  logic [87:0] s_tdata,
	// req_type
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// led_index_out, red_out, green_out, blue_out
	output logic [39:0] m_tdata,
	// status
	output logic [0:0]  m_tuser
);
	localparam int AW = MAX_LEDS > 1 ? $clog2(MAX_LEDS) : 1;
	localparam int KW = KELVIN_ROM_DEPTH > 1 ? $clog2(KELVIN_ROM_DEPTH) : 1;
	localparam int EW = $bits(lcst_pkg::led_entry_t);
	localparam int PW = lcst_pkg::MUL_P_W;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RD, ST_CALC, ST_WR, ST_OUT} state_t;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'd1 + 17'(x[15:8]);
		return s[15:8];
	endfunction

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [2:0]             step_q;
	logic [10:0]            leds_in_use_q;
	logic                   rej_q;
	logic [3:0]             req_q;
	logic [87:0]            in_q;
	lcst_pkg::led_entry_t   ent_q;
	logic [13:0]            sf_q, sg_q;
	logic [7:0]             qv_q, tv_q;
	logic [KW-1:0]          t_q;
	logic                   m_tvalid_q;
	logic [39:0]            m_tdata_q;
	logic                   m_status_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [EW-1:0]          ram_wdata, ram_rdata;
	logic [23:0]            rom_rgb;
	lcst_pkg::mul_op_t      mop;
	logic [PW-1:0]          prod;
	logic [2:0]             sext;
	logic [5:0]             fr;
	logic                   in_range;
	lcst_pkg::led_entry_t   upd;
	logic                   recompute;
	logic [16:0]            t_raw;
	logic [7:0]             pv;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_status_q;

	assign in_range = ({1'b0, s_tdata[15:0]} < 17'(MAX_LEDS)) &&
		({1'b0, s_tdata[15:0]} < {6'd0, leds_in_use_q});

	always_comb begin
		ram_we = 1'b0;
		ram_addr = in_q[AW-1:0];
		ram_wdata = ent_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: ram_addr = s_tdata[AW-1:0];
			ST_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	lcst_ram #(.WIDTH(EW), .DEPTH(MAX_LEDS)) u_state_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	lcst_kelvin_rom #(.DEPTH(KELVIN_ROM_DEPTH)) u_kelvin_rom (
		.clk(clk), .addr(t_q), .rgb(rom_rgb)
	);

	lcst_mul u_mul (.clk(clk), .op(mop), .prod_q(prod));

	// Hue sextant and the remainder within it.
	always_comb begin
		if (ent_q.hue >= 9'd300) sext = 3'd5;
		else if (ent_q.hue >= 9'd240) sext = 3'd4;
		else if (ent_q.hue >= 9'd180) sext = 3'd3;
		else if (ent_q.hue >= 9'd120) sext = 3'd2;
		else if (ent_q.hue >= 9'd60) sext = 3'd1;
		else sext = 3'd0;
		fr = 6'(ent_q.hue - 9'(sext) * 9'd60);
	end

	always_comb begin
		mop = '0;
		if (ent_q.tmode) begin
			case (step_q)
				3'd0: mop = '{a: 20'(ent_q.kel), b: lcst_pkg::RECIP100};
				3'd3: mop = '{a: 20'(rom_rgb[7:0]), b: 21'(ent_q.bri)};
				3'd4: mop = '{a: 20'(rom_rgb[15:8]), b: 21'(ent_q.bri)};
				3'd5: mop = '{a: 20'(rom_rgb[23:16]), b: 21'(ent_q.bri)};
				default: ;
			endcase
		end else begin
			case (step_q)
				3'd0: mop = '{a: 20'(ent_q.sat), b: 21'(fr)};
				3'd1: mop = '{a: 20'(ent_q.sat), b: 21'(6'd60 - fr)};
				3'd2: mop = '{a: 20'(ent_q.bri), b: 21'(14'd15300 - sf_q)};
				3'd3, 3'd5: mop = '{a: prod[21:2], b: lcst_pkg::RECIP15};
				3'd4: mop = '{a: 20'(ent_q.bri), b: 21'(14'd15300 - sg_q)};
				3'd6: mop = '{a: 20'(ent_q.bri), b: 21'(8'd255 - ent_q.sat)};
				default: ;
			endcase
		end
	end

	// Apply the request to the stored entry.
	always_comb begin
		upd = ram_rdata;
		recompute = 1'b1;
		case (req_q)
			lcst_pkg::REQ_ON:     upd.lit = 1'b1;
			lcst_pkg::REQ_OFF:    upd.lit = 1'b0;
			lcst_pkg::REQ_TOGGLE: upd.lit = ~upd.lit;
			lcst_pkg::REQ_RGB: begin
				upd.red = in_q[23:16];
				upd.grn = in_q[31:24];
				upd.blu = in_q[39:32];
				recompute = 1'b0;
			end
			lcst_pkg::REQ_BRIGHT: upd.bri = in_q[47:40];
			lcst_pkg::REQ_SAT:    upd.sat = in_q[55:48];
			lcst_pkg::REQ_HUE: begin
				upd.tmode = 1'b0;
				upd.hue = (in_q[71:56] >= 16'd360) ? 9'd0 : in_q[64:56];
			end
			lcst_pkg::REQ_KELVIN: begin
				upd.tmode = 1'b1;
				upd.kel = in_q[87:72];
			end
			default: recompute = 1'b0;
		endcase
		if (recompute && !upd.lit) begin
			upd.red = '0;
			upd.grn = '0;
			upd.blu = '0;
		end
	end

	assign t_raw = prod[40:24];
	assign pv = div255(prod[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			step_q <= '0;
			leds_in_use_q <= 11'd1024;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) leds_in_use_q <= cfg_wdata;
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_LEDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) state_q <= in_range ? ST_RD : ST_OUT;
				ST_RD: begin
					step_q <= '0;
					state_q <= (recompute && upd.lit) ? ST_CALC : ST_WR;
				end
				ST_CALC: begin
					step_q <= step_q + 1'b1;
					if ((ent_q.tmode && step_q == 3'd6) || (!ent_q.tmode && step_q == 3'd7))
						state_q <= ST_WR;
				end
				ST_WR: state_q <= ST_OUT;
				ST_OUT: if (!m_tvalid_q || m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			in_q <= s_tdata;
			req_q <= s_tuser;
			rej_q <= !in_range;
		end
		if (state_q == ST_RD) ent_q <= upd;
		if (state_q == ST_CALC) begin
			if (ent_q.tmode) begin
				case (step_q)
					3'd1: t_q <= (t_raw > 17'(KELVIN_ROM_DEPTH - 1)) ?
						KW'(KELVIN_ROM_DEPTH - 1) : KW'(t_raw);
					3'd4: ent_q.red <= pv;
					3'd5: ent_q.grn <= pv;
					3'd6: ent_q.blu <= pv;
					default: ;
				endcase
			end else begin
				case (step_q)
					3'd1: sf_q <= prod[13:0];
					3'd2: sg_q <= prod[13:0];
					3'd4: qv_q <= div255(prod[39:24]);
					3'd6: tv_q <= div255(prod[39:24]);
					3'd7: begin
						// pv is the low colour p; qv falls, tv rises across the sextant.
						case (sext)
							3'd0: {ent_q.red, ent_q.grn, ent_q.blu} <= {ent_q.bri, tv_q, pv};
							3'd1: {ent_q.red, ent_q.grn, ent_q.blu} <= {qv_q, ent_q.bri, pv};
							3'd2: {ent_q.red, ent_q.grn, ent_q.blu} <= {pv, ent_q.bri, tv_q};
							3'd3: {ent_q.red, ent_q.grn, ent_q.blu} <= {pv, qv_q, ent_q.bri};
							3'd4: {ent_q.red, ent_q.grn, ent_q.blu} <= {tv_q, pv, ent_q.bri};
							default: {ent_q.red, ent_q.grn, ent_q.blu} <= {ent_q.bri, pv, qv_q};
						endcase
					end
					default: ;
				endcase
			end
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_status_q <= rej_q;
			m_tdata_q <= rej_q ? {24'd0, in_q[15:0]} :
				{ent_q.blu, ent_q.grn, ent_q.red, in_q[15:0]};
		end
	end

`include "led_color_state_table_macros.svh"
	`LCST_ASSERT_NXT(a_one_word_at_a_time, s_tvalid && s_tready, !s_tready)
	`LCST_ASSERT_IMP(a_reject_gives_zero, m_tvalid && m_tuser[0], m_tdata[39:16] == 24'd0)
	`LCST_ASSERT_IMP(a_ram_write_only_clear_or_wb, ram_we,
		state_q == ST_CLEAR || state_q == ST_WR)
endmodule
